FILE: hw/rtl/vrri_pkg.sv
`timescale 1ns / 1ps

package vrri_pkg;

   // Fixed geometry of the register file
   localparam int ADDR_W       = 6;
   localparam int DATA_W       = 8;
   localparam int ELAPSED_W    = 5;
   localparam int ROW_W        = 9;
   localparam int CYCLE_W      = 7;
   localparam int REG_SPACE    = 64;
   localparam int SPRITE_COUNT = 8;
   localparam int BG_COUNT     = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINES_PER_FRAME = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLES_PER_LINE = 1'd1;
   localparam logic [ROW_W-1:0]   LINES_PER_FRAME_RST = 9'd312;
   localparam logic [CYCLE_W-1:0] CYCLES_PER_LINE_RST = 7'd63;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // Register map
   localparam logic [ADDR_W-1:0] REG_SPR_HIGH  = 6'h10;
   localparam logic [ADDR_W-1:0] REG_CTRL_ONE  = 6'h11;
   localparam logic [ADDR_W-1:0] REG_RASTER    = 6'h12;
   localparam logic [ADDR_W-1:0] REG_PEN_X     = 6'h13;
   localparam logic [ADDR_W-1:0] REG_PEN_Y     = 6'h14;
   localparam logic [ADDR_W-1:0] REG_SPR_EN    = 6'h15;
   localparam logic [ADDR_W-1:0] REG_CTRL_TWO  = 6'h16;
   localparam logic [ADDR_W-1:0] REG_MEM_PTR   = 6'h18;
   localparam logic [ADDR_W-1:0] REG_IRQ_STAT  = 6'h19;
   localparam logic [ADDR_W-1:0] REG_IRQ_MASK  = 6'h1a;
   localparam logic [ADDR_W-1:0] REG_BORDER    = 6'h20;
   localparam logic [ADDR_W-1:0] REG_BG0       = 6'h21;
   localparam logic [ADDR_W-1:0] REG_BG3       = 6'h24;

   // Badline window and status read constants
   localparam logic [ROW_W-1:0]  BADLINE_FIRST = 9'h030;
   localparam logic [ROW_W-1:0]  BADLINE_LAST  = 9'h0f7;
   localparam logic [2:0]        IRQ_STAT_ONES = 3'b111;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_W-1:0]       reg_address;
      logic [DATA_W-1:0]       write_value;
      logic [ELAPSED_W-1:0]    elapsed_cycles;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              irq_raised;
      logic              cpu_stall;
      logic              frame_end;
   } result_type;

   typedef struct packed {
      logic                   write_enable;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  write_data;
   } csr_type;

   function automatic logic is_sprite(logic [ADDR_W-1:0] addr);
      return (addr[5:4] == 2'b00) && ({1'b0, addr[3:1]} < 4'(SPRITE_COUNT));
   endfunction

   function automatic logic is_shadow(logic [ADDR_W-1:0] addr);
      logic named;
      named = addr inside {REG_SPR_HIGH, REG_CTRL_ONE, REG_RASTER, REG_PEN_X,
                           REG_PEN_Y, REG_SPR_EN, REG_CTRL_TWO, REG_MEM_PTR,
                           REG_IRQ_STAT, REG_IRQ_MASK, REG_BORDER,
                           [REG_BG0:REG_BG3]};
      return !named && !is_sprite(addr) && ({1'b0, addr} < 7'(REG_SPACE));
   endfunction

endpackage

FILE: hw/rtl/vrri_ram.sv
`timescale 1ns / 1ps

module vrri_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/vrri_shadow.sv
`timescale 1ns / 1ps

module vrri_shadow (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  vrri_pkg::item_type           item,
   output logic [vrri_pkg::DATA_W-1:0]  rd_data
);
   import vrri_pkg::*;

   logic                  written_ff [REG_SPACE];
   logic                  rd_written_ff;
   logic                  wr_en;
   logic [DATA_W-1:0]     ram_data;

   // Writes land at transfer time, so reads and writes stay in item order
   assign wr_en = accept && (item.kind == KIND_WRITE) && is_shadow(item.reg_address);

   vrri_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_SPACE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (item.reg_address),
      .wr_data (item.write_value),
      .rd_en   (accept),
      .rd_addr (item.reg_address),
      .rd_data (ram_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_SPACE; i++) begin
            written_ff[i] <= 1'b0;
         end
         rd_written_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[item.reg_address] <= 1'b1;
         end
         if (accept) begin
            rd_written_ff <= written_ff[item.reg_address];
         end
      end
   end

   // An entry never written reads as zero
   assign rd_data = rd_written_ff ? ram_data : '0;

endmodule

FILE: hw/rtl/vrri_regs.sv
`timescale 1ns / 1ps

module vrri_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  vrri_pkg::csr_type            csr,
   input  logic                         retire,
   input  vrri_pkg::item_type           item,
   input  logic [vrri_pkg::DATA_W-1:0]  shadow_data,
   output vrri_pkg::result_type         result
);
   import vrri_pkg::*;

   logic [ROW_W-1:0]   lines_per_frame_ff, lines_per_frame_in;
   logic [CYCLE_W-1:0] cycles_per_line_ff, cycles_per_line_in;

   logic [DATA_W-1:0]  sprite_x_ff [SPRITE_COUNT];
   logic [DATA_W-1:0]  sprite_y_ff [SPRITE_COUNT];
   logic [DATA_W-1:0]  bg_ff [BG_COUNT];
   logic [DATA_W-1:0]  spr_high_ff, spr_high_in;
   logic [DATA_W-1:0]  ctrl_one_ff, ctrl_one_in;
   logic [DATA_W-1:0]  ctrl_two_ff, ctrl_two_in;
   logic [DATA_W-1:0]  raster_low_ff, raster_low_in;
   logic [ROW_W-1:0]   compare_ff, compare_in;
   logic [DATA_W-1:0]  pen_x_ff, pen_x_in;
   logic [DATA_W-1:0]  pen_y_ff, pen_y_in;
   logic [DATA_W-1:0]  spr_en_ff, spr_en_in;
   logic [DATA_W-1:0]  mem_ptr_ff, mem_ptr_in;
   logic [3:0]         irq_flags_ff, irq_flags_in;
   logic [3:0]         irq_mask_ff, irq_mask_in;
   logic [DATA_W-1:0]  border_ff, border_in;
   logic [CYCLE_W-1:0] line_count_ff, line_count_in;

   logic               is_rd, is_wr, is_tick;
   logic               spr_wr, bg_wr;
   logic [1:0]         bg_idx;
   logic [2:0]         spr_idx;
   logic [CYCLE_W:0]   sum, sum_left;
   logic               line_done;
   logic [ROW_W-1:0]   row;
   logic [ROW_W:0]     row_next;
   logic               wrap;
   logic [ROW_W-1:0]   row_new;

   assign is_rd   = retire && (item.kind == KIND_READ);
   assign is_wr   = retire && (item.kind == KIND_WRITE);
   assign is_tick = retire && (item.kind == KIND_TICK);
   assign spr_idx = item.reg_address[3:1];
   assign bg_idx  = 2'(item.reg_address - REG_BG0);
   assign spr_wr  = is_wr && is_sprite(item.reg_address);
   assign bg_wr   = is_wr && (item.reg_address inside {[REG_BG0:REG_BG3]});

   // Line timing: add the elapsed cycles, close at most one line per tick
   assign sum       = {1'b0, line_count_ff} + {3'b000, item.elapsed_cycles};
   assign line_done = sum >= {1'b0, cycles_per_line_ff};
   assign sum_left  = line_done ? (sum - {1'b0, cycles_per_line_ff}) : sum;
   assign row       = {ctrl_one_ff[7], raster_low_ff};
   assign row_next  = {1'b0, row} + 10'd1;
   assign wrap      = row_next >= {1'b0, lines_per_frame_ff};
   assign row_new   = wrap ? '0 : row_next[ROW_W-1:0];

   always_comb begin
      result = '0;
      if (is_tick && line_done) begin
         result.cpu_stall  = (row >= BADLINE_FIRST) && (row <= BADLINE_LAST) &&
                             (row[2:0] == ctrl_one_ff[2:0]);
         result.irq_raised = irq_mask_ff[0] && (row == compare_ff);
         result.frame_end  = wrap;
      end
      if (is_rd) begin
         case (item.reg_address)
            REG_SPR_HIGH: result.read_value = spr_high_ff;
            REG_CTRL_ONE: result.read_value = ctrl_one_ff;
            REG_RASTER:   result.read_value = raster_low_ff;
            REG_PEN_X:    result.read_value = pen_x_ff;
            REG_PEN_Y:    result.read_value = pen_y_ff;
            REG_SPR_EN:   result.read_value = spr_en_ff;
            REG_CTRL_TWO: result.read_value = ctrl_two_ff;
            REG_MEM_PTR:  result.read_value = mem_ptr_ff;
            REG_IRQ_STAT: result.read_value = {(|irq_flags_ff), IRQ_STAT_ONES, irq_flags_ff};
            REG_IRQ_MASK: result.read_value = {4'b0000, irq_mask_ff};
            REG_BORDER:   result.read_value = border_ff;
            default: begin
               if (item.reg_address inside {[REG_BG0:REG_BG3]}) begin
                  result.read_value = bg_ff[bg_idx];
               end else if (is_sprite(item.reg_address)) begin
                  result.read_value = item.reg_address[0] ? sprite_y_ff[spr_idx]
                                                          : sprite_x_ff[spr_idx];
               end else if (is_shadow(item.reg_address)) begin
                  result.read_value = shadow_data;
               end
            end
         endcase
      end
   end

   always_comb begin
      lines_per_frame_in = lines_per_frame_ff;
      cycles_per_line_in = cycles_per_line_ff;
      spr_high_in   = spr_high_ff;
      ctrl_one_in   = ctrl_one_ff;
      ctrl_two_in   = ctrl_two_ff;
      raster_low_in = raster_low_ff;
      compare_in    = compare_ff;
      pen_x_in      = pen_x_ff;
      pen_y_in      = pen_y_ff;
      spr_en_in     = spr_en_ff;
      mem_ptr_in    = mem_ptr_ff;
      irq_flags_in  = irq_flags_ff;
      irq_mask_in   = irq_mask_ff;
      border_in     = border_ff;
      line_count_in = line_count_ff;

      if (csr.write_enable) begin
         case (csr.index)
            CSR_LINES_PER_FRAME: lines_per_frame_in = csr.write_data;
            CSR_CYCLES_PER_LINE: cycles_per_line_in = csr.write_data[CYCLE_W-1:0];
            default: ;
         endcase
      end

      if (is_wr) begin
         case (item.reg_address)
            REG_SPR_HIGH: spr_high_in = item.write_value;
            REG_CTRL_ONE: begin
               ctrl_one_in = {ctrl_one_ff[7], item.write_value[6:0]};
               compare_in  = {item.write_value[7], compare_ff[7:0]};
            end
            REG_RASTER:   compare_in = {compare_ff[8], item.write_value};
            REG_PEN_X:    pen_x_in = item.write_value;
            REG_PEN_Y:    pen_y_in = item.write_value;
            REG_SPR_EN:   spr_en_in = item.write_value;
            REG_CTRL_TWO: ctrl_two_in = item.write_value;
            REG_MEM_PTR:  mem_ptr_in = {item.write_value[7:1], 1'b1};
            REG_IRQ_STAT: irq_flags_in = irq_flags_ff & ~item.write_value[3:0];
            REG_IRQ_MASK: irq_mask_in = item.write_value[3:0];
            REG_BORDER:   border_in = item.write_value;
            default: ;
         endcase
      end

      if (is_tick) begin
         if (line_done) begin
            if (result.irq_raised) begin
               irq_flags_in = irq_flags_ff | 4'b0001;
            end
            ctrl_one_in   = {row_new[8], ctrl_one_ff[6:0]};
            raster_low_in = row_new[7:0];
         end
         // Saturate the cycle count
         line_count_in = sum_left[CYCLE_W] ? {CYCLE_W{1'b1}} : sum_left[CYCLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_per_frame_ff <= LINES_PER_FRAME_RST;
         cycles_per_line_ff <= CYCLES_PER_LINE_RST;
         for (int i = 0; i < SPRITE_COUNT; i++) begin
            sprite_x_ff[i] <= '0;
            sprite_y_ff[i] <= '0;
         end
         for (int i = 0; i < BG_COUNT; i++) begin
            bg_ff[i] <= '0;
         end
         spr_high_ff   <= '0;
         ctrl_one_ff   <= '0;
         ctrl_two_ff   <= '0;
         raster_low_ff <= '0;
         compare_ff    <= '0;
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         spr_en_ff     <= '0;
         mem_ptr_ff    <= 8'h01;
         irq_flags_ff  <= '0;
         irq_mask_ff   <= '0;
         border_ff     <= '0;
         line_count_ff <= '0;
      end else begin
         lines_per_frame_ff <= lines_per_frame_in;
         cycles_per_line_ff <= cycles_per_line_in;
         if (spr_wr) begin
            if (item.reg_address[0]) begin
               sprite_y_ff[spr_idx] <= item.write_value;
            end else begin
               sprite_x_ff[spr_idx] <= item.write_value;
            end
         end
         if (bg_wr) begin
            bg_ff[bg_idx] <= item.write_value;
         end
         spr_high_ff   <= spr_high_in;
         ctrl_one_ff   <= ctrl_one_in;
         ctrl_two_ff   <= ctrl_two_in;
         raster_low_ff <= raster_low_in;
         compare_ff    <= compare_in;
         pen_x_ff      <= pen_x_in;
         pen_y_ff      <= pen_y_in;
         spr_en_ff     <= spr_en_in;
         mem_ptr_ff    <= mem_ptr_in;
         irq_flags_ff  <= irq_flags_in;
         irq_mask_ff   <= irq_mask_in;
         border_ff     <= border_in;
         line_count_ff <= line_count_in;
      end
   end

   a_frame_end_row_zero: assert property (@(posedge clock) disable iff (reset)
      result.frame_end |=> (ctrl_one_ff[7] == 1'b0) && (raster_low_ff == '0))
      else $error("row not zero after frame end");

   a_irq_sets_flag: assert property (@(posedge clock) disable iff (reset)
      result.irq_raised |=> irq_flags_ff[0])
      else $error("raster interrupt did not set its flag");

   a_mem_ptr_bit0: assert property (@(posedge clock) disable iff (reset)
      mem_ptr_ff[0])
      else $error("memory pointer bit 0 cleared");

endmodule

FILE: hw/rtl/video_chip_registers_raster_irq_core.sv
`timescale 1ns / 1ps

// Raster video chip register file with line counter and raster interrupt.
//
// Request channel (req_*): one item per transfer, a register read, a register
// write or a cycle tick. Result channel (rsp_*): exactly one result per item,
// in order. Both channels transfer when valid is high and stall is low.
// Configuration port (csr_*): index 0 sets lines per frame, index 1 sets
// cycles per line; write only while no item is in flight.
//
// A transferred item is captured in an input stage (the shadow store RAM
// read is launched at the same edge), then decoded and applied against the
// register state once the output register is free, and the result is loaded
// into the output register. One item per cycle is sustained while the
// receiver does not stall. When the receiver stalls, the output register
// holds its result, the input stage keeps its item, and req_stall rises
// so the sender holds. Synchronous reset clears both stages, loads the
// register reset values (memory pointer reads 1, 312 lines per frame,
// cycles per line from CYCLES_PER_LINE_RST) and marks all 64 shadow entries
// unwritten, so they read zero; no clearing pass.

module video_chip_registers_raster_irq_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_kind,
   input  logic [vrri_pkg::ADDR_W-1:0]       req_reg_address,
   input  logic [vrri_pkg::DATA_W-1:0]       req_write_value,
   input  logic [vrri_pkg::ELAPSED_W-1:0]    req_elapsed_cycles,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vrri_pkg::DATA_W-1:0]       rsp_read_value,
   output logic                              rsp_irq_raised,
   output logic                              rsp_cpu_stall,
   output logic                              rsp_frame_end,
   input  logic                              csr_write_enable,
   input  logic [vrri_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [vrri_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import vrri_pkg::*;

   item_type    req_item;
   item_type    s1_item_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   result_type  result;
   csr_type     csr;
   logic        advance;
   logic        accept;
   logic [DATA_W-1:0] shadow_data;

   assign req_item.kind           = kind_type'(req_kind);
   assign req_item.reg_address    = req_reg_address;
   assign req_item.write_value    = req_write_value;
   assign req_item.elapsed_cycles = req_elapsed_cycles;

   assign csr.write_enable = csr_write_enable;
   assign csr.index        = csr_index;
   assign csr.write_data   = csr_write_data;

   // Output slot frees when empty or taken this cycle
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   vrri_shadow u_shadow (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .item    (req_item),
      .rd_data (shadow_data)
   );

   vrri_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr),
      .retire      (advance),
      .item        (s1_item_ff),
      .shadow_data (shadow_data),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload stages: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_irq_raised = rsp_ff.irq_raised;
   assign rsp_cpu_stall  = rsp_ff.cpu_stall;
   assign rsp_frame_end  = rsp_ff.frame_end;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a held item");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("transferred item lost from input stage");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("retired item produced no result");

endmodule
